>>> design/rafl_pkg.sv
package rafl_pkg;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] MODE_DENY_LIST = 2'd0;
  localparam logic [1:0] MODE_ALLOW_LIST = 2'd1;

  localparam logic VERDICT_ALLOW = 1'b0;
  localparam logic VERDICT_DENY = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] mask;
  } rule_t;

  typedef struct packed {
    logic valid;
    logic verdict;
    logic status;
  } res_t;

endpackage

>>> design/rafl_rule_mem.sv
module rafl_rule_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  rafl_pkg::rule_t       wdata_i,
  input  logic [IdxW-1:0]       raddr_i,
  output rafl_pkg::rule_t       rdata_o
);

  rafl_pkg::rule_t mem_q [Depth];
  rafl_pkg::rule_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rafl_seq.sv
module rafl_seq #(
  parameter int unsigned MaxRules = 64,
  parameter int unsigned CntW = 7,
  parameter int unsigned IdxW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [31:0]       route_address_i,
  input  logic [31:0]       route_mask_i,
  input  logic [1:0]        mode_i,
  output rafl_pkg::res_t    res_o,
  input  logic              res_ready_i,
  output logic              mem_we_o,
  output logic [IdxW-1:0]   mem_waddr_o,
  output rafl_pkg::rule_t   mem_wdata_o,
  output logic [IdxW-1:0]   mem_raddr_o,
  input  rafl_pkg::rule_t   mem_rdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic cmp_valid_q, cmp_valid_d;
  logic hit_q, hit_d;
  logic lookup_q, lookup_d;
  logic full_st_q, full_st_d;
  rafl_pkg::rule_t key_q, key_d;
  logic accept;
  logic full;
  logic last;
  logic verdict;

  assign accept = in_valid_i && in_ready_o;
  assign full = (count_q == CntW'(MaxRules));
  assign last = ((idx_q + CntW'(1)) == count_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign mem_we_o = accept && (operation_i == rafl_pkg::OP_APPEND) && !full;
  assign mem_waddr_o = count_q[IdxW-1:0];
  assign mem_wdata_o = '{addr: route_address_i, mask: route_mask_i};
  assign mem_raddr_o = idx_q[IdxW-1:0];

  always_comb begin
    case (mode_i)
      rafl_pkg::MODE_DENY_LIST:  verdict = hit_q ? rafl_pkg::VERDICT_DENY
                                                 : rafl_pkg::VERDICT_ALLOW;
      rafl_pkg::MODE_ALLOW_LIST: verdict = hit_q ? rafl_pkg::VERDICT_ALLOW
                                                 : rafl_pkg::VERDICT_DENY;
      default:                   verdict = rafl_pkg::VERDICT_DENY;
    endcase
  end

  always_comb begin
    res_o.valid = (state_q == ST_DONE);
    res_o.verdict = lookup_q ? verdict : rafl_pkg::VERDICT_ALLOW;
    res_o.status = full_st_q;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d = idx_q;
    cmp_valid_d = 1'b0;
    hit_d = hit_q;
    lookup_d = lookup_q;
    full_st_d = full_st_q;
    key_d = key_q;
    if (cmp_valid_q && (mem_rdata_i == key_q)) begin
      hit_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d = '{addr: route_address_i, mask: route_mask_i};
          hit_d = 1'b0;
          idx_d = '0;
          if (operation_i == rafl_pkg::OP_APPEND) begin
            lookup_d = 1'b0;
            state_d = ST_DONE;
            if (full) begin
              full_st_d = rafl_pkg::STATUS_FULL;
            end else begin
              full_st_d = rafl_pkg::STATUS_OK;
              count_d = count_q + CntW'(1);
            end
          end else begin
            lookup_d = 1'b1;
            full_st_d = rafl_pkg::STATUS_OK;
            state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmp_valid_d = 1'b1;
        if (last) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cmp_valid_q <= cmp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    hit_q <= hit_d;
    lookup_q <= lookup_d;
    full_st_q <= full_st_d;
    key_q <= key_d;
  end

endmodule

>>> design/route_allow_deny_filter_core.sv
// Exact-match route filter that stores up to MAX_RULES address and mask pairs in one
// synchronous memory and answers every transaction with one verdict and status result. An
// append transaction, or a lookup on an empty table, goes from acceptance straight to the
// done state, and its result is then registered into the output register. Any other lookup
// scans every stored rule, because the single memory read port delivers one stored rule
// per cycle to the comparator, and then passes a drain state before the done state. In
// either case the next transaction can be accepted once the result enters the output
// register; a result waiting there does not stop the next from being accepted and started.
module route_allow_deny_filter_core #(
  parameter int unsigned MAX_RULES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] route_address_i,
  input  logic [31:0] route_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        verdict_o,
  output logic        status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_RULES + 1);
  localparam int unsigned IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  logic [1:0] mode_q;
  logic out_valid_q;
  logic verdict_q;
  logic status_q;
  logic res_ready;
  rafl_pkg::res_t res;
  logic mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [IdxW-1:0] mem_raddr;
  rafl_pkg::rule_t mem_wdata;
  rafl_pkg::rule_t mem_rdata;

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rafl_pkg::MODE_DENY_LIST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (res_ready) begin
        out_valid_q <= res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      verdict_q <= res.verdict;
      status_q <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o = verdict_q;
  assign status_o = status_q;

  rafl_seq #(
    .MaxRules(MAX_RULES),
    .CntW(CntW),
    .IdxW(IdxW)
  ) u_seq (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .operation_i(operation_i),
    .route_address_i(route_address_i),
    .route_mask_i(route_mask_i),
    .mode_i(mode_q),
    .res_o(res),
    .res_ready_i(res_ready),
    .mem_we_o(mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  rafl_rule_mem #(
    .Depth(MAX_RULES),
    .IdxW(IdxW)
  ) u_mem (
    .clk_i(clk_i),
    .we_i(mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

>>> design/rafl_checker.sv
module rafl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic verdict_o,
  input logic status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o) && $stable(status_o))
    else $error("Result changed while stalled.");

  a_no_deny_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(verdict_o && status_o))
    else $error("Full status and deny verdict in one result.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Ready stayed high after a transaction was accepted.");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("Result appeared without a transaction in progress.");

endmodule

bind route_allow_deny_filter_core rafl_checker u_rafl_checker (.*);
